>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the linear score classifier.
// No dependencies; the bodies compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/lsac_pkg.sv
// Package of the linear score classifier: beat types, codes and widths.
// Used by lsac_lane, lsac_merge and linear_score_argmax_classifier.
package lsac_pkg;

    localparam int PROD_W     = 49;
    localparam int SCORE_W    = 53;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] MODE_LOAD_COEF  = 2'd0;
    localparam logic [1:0] MODE_LOAD_CLASS = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_EN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VAL = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_CNT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_CNT  = 4'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         class_slot;
        logic [3:0]         feature_slot;
        logic signed [31:0] load_value;
        logic [15:0]        band_zero;
        logic [15:0]        band_one;
        logic [15:0]        band_two;
        logic [15:0]        band_three;
        logic [15:0]        band_four;
        logic [15:0]        band_five;
        logic [15:0]        band_six;
        logic [15:0]        band_seven;
    } t_in;

    typedef struct packed {
        logic [15:0] class_label;
        logic [3:0]  winner_slot;
        logic        no_data;
    } t_out;

    // Control that travels with one class row through the lanes and the merge.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/lsac_lane.sv
// One coefficient lane: a weight memory indexed by class slot and a multiplier.
// Depends on lsac_pkg for the product width.
module lsac_lane #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [ADDR_W-1:0]                 i_wr_addr,
    input  logic signed [31:0]                i_wr_data,
    input  logic [ADDR_W-1:0]                 i_rd_addr,
    input  logic [15:0]                       i_sample,
    output logic signed [lsac_pkg::PROD_W-1:0] o_product
);
    import lsac_pkg::*;

    logic signed [31:0]       r_mem [0:DEPTH-1];
    logic signed [31:0]       r_weight;
    logic signed [16:0]       w_sample;
    logic signed [PROD_W-1:0] r_product;

    assign w_sample = $signed({1'b0, i_sample});

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_weight  <= r_mem[i_rd_addr];
        r_product <= r_weight * w_sample;
    end

    assign o_product = r_product;

endmodule

>>> hw/rtl/lsac_merge.sv
// Merge stage: registered adder tree over the lane products, then a running
// maximum over class rows. Depends on lsac_pkg for t_tok and the widths.
module lsac_merge #(
    parameter int NLANES = 9,
    parameter int SLOT_W = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [lsac_pkg::PROD_W-1:0] i_prod [0:NLANES-1],
    input  lsac_pkg::t_tok                    i_tok,
    output logic                              o_done,
    output logic [SLOT_W-1:0]                 o_best_slot
);
    import lsac_pkg::*;

    localparam int LVL = $clog2(NLANES);
    localparam int NL  = 1 << LVL;

    logic signed [SCORE_W-1:0] w_leaf [0:NL-1];
    logic signed [SCORE_W-1:0] r_node [1:NL-1];
    t_tok                      r_tok_pipe [1:LVL];
    t_tok                      w_root_tok;
    logic signed [SCORE_W-1:0] r_best_score;
    logic [SLOT_W-1:0]         r_best_slot;
    logic [SLOT_W-1:0]         r_cur_slot;
    logic                      r_done;

    for (genvar n = 0; n < NL; n++) begin : g_leaf
        if (n < NLANES) begin : g_used
            assign w_leaf[n] = SCORE_W'(i_prod[n]);
        end else begin : g_pad
            assign w_leaf[n] = '0;
        end
    end

    // Heap layout: node n adds children 2n and 2n+1; the bottom row reads leaves.
    for (genvar n = 1; n < NL; n++) begin : g_node
        if (2 * n >= NL) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_node[n] <= w_leaf[2*n-NL] + w_leaf[2*n+1-NL];
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[n] <= r_node[2*n] + r_node[2*n+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LVL; k++) begin
                r_tok_pipe[k] <= '0;
            end
        end else begin
            r_tok_pipe[1] <= i_tok;
            for (int k = 2; k <= LVL; k++) begin
                r_tok_pipe[k] <= r_tok_pipe[k-1];
            end
        end
    end

    assign w_root_tok = r_tok_pipe[LVL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_root_tok.valid && w_root_tok.last;
        end
    end

    // Only a strictly higher score replaces the best, so the lowest slot wins ties.
    always_ff @(posedge i_clk) begin
        if (w_root_tok.valid) begin
            if (w_root_tok.first) begin
                r_best_score <= r_node[1];
                r_best_slot  <= '0;
                r_cur_slot   <= SLOT_W'(1);
            end else begin
                if (r_node[1] > r_best_score) begin
                    r_best_score <= r_node[1];
                    r_best_slot  <= r_cur_slot;
                end
                r_cur_slot <= r_cur_slot + 1'b1;
            end
        end
    end

    assign o_done      = r_done;
    assign o_best_slot = r_best_slot;

endmodule

>>> hw/rtl/linear_score_argmax_classifier.sv
// Top level of the linear score classifier: beat handshakes, configuration,
// class sequencer and class id table. Depends on lsac_pkg, lsac_lane, lsac_merge.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A load beat leaves the block idle for the next beat. For N classes in use, a pixel
// beat issues one class row per cycle to the band lanes, which multiply in parallel,
// and the adder tree adds one level per cycle. The result is registered after the
// running maximum and the class id read, and the next beat is taken after that. A
// no-data pixel skips the lanes. Reset is synchronous; the weight and class id
// memories hold no reset value. A stalled output holds its beat while the next pixel
// is already being scored, which then waits for that beat.
`include "assert_macros.svh"

module linear_score_argmax_classifier #(
    parameter int MAX_BANDS   = 8,
    parameter int MAX_CLASSES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lsac_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lsac_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lsac_pkg::*;

    localparam int NLANES = MAX_BANDS + 1;
    localparam int SLOT_W = $clog2(MAX_CLASSES);
    localparam int CNT_W  = $clog2(MAX_CLASSES + 1);

    logic                     r_nodata_en;
    logic [15:0]              r_nodata_val;
    logic [3:0]               r_band_count;
    logic [4:0]               r_class_count;

    t_state                   r_state;
    t_state                   n_state;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        r_last_slot;
    logic                     r_nodata_flag;
    logic [15:0]              r_sample [0:MAX_BANDS-1];
    t_tok                     w_tok;
    t_tok                     r_tok_d1;
    t_tok                     r_tok_d2;

    logic [15:0]              r_cid_mem [0:MAX_CLASSES-1];
    logic [15:0]              r_cid;
    logic                     r_out_valid;
    t_out                     r_out;

    logic                     w_in_acc;
    logic                     w_classify;
    logic                     w_is_nodata;
    logic                     w_slot_ok;
    logic                     w_coef_wr;
    logic                     w_cid_wr;
    logic                     w_issue;
    logic                     w_out_load;
    logic                     w_done;
    logic [SLOT_W-1:0]        w_best_slot;
    logic [SLOT_W-1:0]        w_wr_slot;
    logic [3:0]               w_nb;
    logic [CNT_W-1:0]         w_nc;
    logic [15:0]              w_band [0:7];
    logic signed [PROD_W-1:0] w_prod [0:NLANES-1];

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodata_en   <= 1'b0;
            r_nodata_val  <= '0;
            r_band_count  <= 4'd1;
            r_class_count <= 5'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NODATA_EN:  r_nodata_en   <= i_cfg_data[0];
                CFG_NODATA_VAL: r_nodata_val  <= i_cfg_data;
                CFG_BAND_CNT:   r_band_count  <= i_cfg_data[3:0];
                CFG_CLASS_CNT:  r_class_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_band[0] = i_in_data.band_zero;
    assign w_band[1] = i_in_data.band_one;
    assign w_band[2] = i_in_data.band_two;
    assign w_band[3] = i_in_data.band_three;
    assign w_band[4] = i_in_data.band_four;
    assign w_band[5] = i_in_data.band_five;
    assign w_band[6] = i_in_data.band_six;
    assign w_band[7] = i_in_data.band_seven;

    always_comb begin
        if (r_band_count == '0) begin
            w_nb = 4'd1;
        end else if (32'(r_band_count) > MAX_BANDS) begin
            w_nb = 4'(MAX_BANDS);
        end else begin
            w_nb = r_band_count;
        end
        if (r_class_count == '0) begin
            w_nc = CNT_W'(1);
        end else if (32'(r_class_count) > MAX_CLASSES) begin
            w_nc = CNT_W'(MAX_CLASSES);
        end else begin
            w_nc = CNT_W'(r_class_count);
        end
    end

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_classify  = w_in_acc && (i_in_data.mode == MODE_CLASSIFY);
    assign w_is_nodata = r_nodata_en && (i_in_data.band_zero == r_nodata_val);
    assign w_slot_ok   = 32'(i_in_data.class_slot) < MAX_CLASSES;
    assign w_wr_slot   = SLOT_W'(i_in_data.class_slot);
    assign w_coef_wr   = w_in_acc && (i_in_data.mode == MODE_LOAD_COEF) && w_slot_ok;
    assign w_cid_wr    = w_in_acc && (i_in_data.mode == MODE_LOAD_CLASS) && w_slot_ok;

    // Sequencer state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_classify) begin
                    n_state = w_is_nodata ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_slot == r_last_slot) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_ISSUE: w_issue    = 1'b1;
            ST_WAIT:  ;
            ST_DONE:  w_out_load = !r_out_valid || i_out_ready;
            default:  ;
        endcase
    end

    // Unused bands are zeroed here so their lanes add nothing to the score.
    always_ff @(posedge i_clk) begin
        if (w_classify) begin
            r_nodata_flag <= w_is_nodata;
            r_last_slot   <= SLOT_W'(w_nc - 1'b1);
            for (int b = 0; b < MAX_BANDS; b++) begin
                r_sample[b] <= (4'(b) < w_nb) ? w_band[b] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (w_classify) begin
            r_slot <= '0;
        end else if (w_issue) begin
            r_slot <= r_slot + 1'b1;
        end
    end

    assign w_tok.valid = w_issue;
    assign w_tok.first = (r_slot == '0);
    assign w_tok.last  = (r_slot == r_last_slot);

    // The token registers r_tok_d1 and r_tok_d2 match the weight read and the multiply registers in the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_d1 <= '0;
            r_tok_d2 <= '0;
        end else begin
            r_tok_d1 <= w_tok;
            r_tok_d2 <= r_tok_d1;
        end
    end

    // Lane 0 carries the intercept, scaled by a constant sample of one.
    for (genvar f = 0; f < NLANES; f++) begin : g_lane
        logic [15:0] w_lane_sample;

        if (f == 0) begin : g_icpt
            assign w_lane_sample = 16'd1;
        end else begin : g_band
            assign w_lane_sample = r_sample[f-1];
        end

        lsac_lane #(
            .DEPTH  (MAX_CLASSES),
            .ADDR_W (SLOT_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (w_coef_wr && (i_in_data.feature_slot == 4'(f))),
            .i_wr_addr (w_wr_slot),
            .i_wr_data (i_in_data.load_value),
            .i_rd_addr (r_slot),
            .i_sample  (w_lane_sample),
            .o_product (w_prod[f])
        );
    end

    lsac_merge #(
        .NLANES (NLANES),
        .SLOT_W (SLOT_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prod      (w_prod),
        .i_tok       (r_tok_d2),
        .o_done      (w_done),
        .o_best_slot (w_best_slot)
    );

    // Class id table; the winner slot is stable from the done pulse onward.
    always_ff @(posedge i_clk) begin
        if (w_cid_wr) begin
            r_cid_mem[w_wr_slot] <= i_in_data.load_value[15:0];
        end
        r_cid <= r_cid_mem[w_best_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.class_label <= r_nodata_flag ? 16'd0 : r_cid;
            r_out.winner_slot <= r_nodata_flag ? 4'd0 : 4'(w_best_slot);
            r_out.no_data     <= r_nodata_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NXT(a_busy_after_pixel, i_clk, i_rst_n, w_classify, !o_in_ready)
    `ASSERT_IMP(a_done_while_waiting, i_clk, i_rst_n, w_done, r_state == ST_WAIT)
    `ASSERT_IMP(a_nodata_fields, i_clk, i_rst_n, o_out_valid && o_out_data.no_data,
        (o_out_data.class_label == 16'd0) && (o_out_data.winner_slot == 4'd0))

endmodule

>>> bench/tb_top.sv
// Self-checking bench for linear_score_argmax_classifier: loads, pixels and
// register writes, with every result checked against a scoring model of its own.
// Depends on lsac_pkg and the classifier RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsac_pkg::*;

    localparam int BANDS_MAX    = 8;
    localparam int SLOTS_MAX    = 16;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_WAIT  = 32;
    localparam int SINK_HOLD    = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int IDLE_PERCENT = 29;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

    // Register settings of the first five phases, phase 0 in the low slice.
    localparam logic [4:0]  FIX_EN  = 5'b01101;
    localparam logic [79:0] FIX_VAL = {16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF};
    localparam logic [19:0] FIX_BC  = {4'd9, 4'd15, 4'd0, 4'd1, 4'd8};
    localparam logic [24:0] FIX_CC  = {5'd17, 5'd31, 5'd1, 5'd2, 5'd16};

    class argmax_scoreboard;
        logic signed [31:0] weights [SLOTS_MAX][BANDS_MAX+1];
        logic [15:0]        class_ids [SLOTS_MAX];
        logic               nodata_en;
        logic [15:0]        nodata_val;
        logic [3:0]         band_cnt;
        logic [4:0]         class_cnt;
        t_out               pending_labels [$];
        int                 fails;

        function new();
            nodata_en  = 1'b0;
            nodata_val = '0;
            band_cnt   = 4'd1;
            class_cnt  = 5'd2;
            fails      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NODATA_EN:  nodata_en  = data[0];
                CFG_NODATA_VAL: nodata_val = data[15:0];
                CFG_BAND_CNT:   band_cnt   = data[3:0];
                CFG_CLASS_CNT:  class_cnt  = data[4:0];
                default: ;
            endcase
        endfunction

        function t_out score_pixel(t_in px);
            t_out        lbl;
            logic [15:0] bands [BANDS_MAX];
            longint      best_score;
            longint      sc;
            int          nb;
            int          nc;
            int          best;
            bands = '{px.band_zero, px.band_one, px.band_two, px.band_three,
                      px.band_four, px.band_five, px.band_six, px.band_seven};
            lbl = '0;
            if (nodata_en && px.band_zero == nodata_val) begin
                lbl.no_data = 1'b1;
                return lbl;
            end
            // Out-of-range counts clamp into the supported range.
            nb = int'(band_cnt);
            if (nb < 1) nb = 1;
            if (nb > BANDS_MAX) nb = BANDS_MAX;
            nc = int'(class_cnt);
            if (nc < 1) nc = 1;
            if (nc > SLOTS_MAX) nc = SLOTS_MAX;
            best = 0;
            best_score = 0;
            for (int s = 0; s < nc; s++) begin
                sc = longint'(weights[s][0]);
                for (int b = 0; b < nb; b++) begin
                    sc += longint'(weights[s][b+1]) * longint'(bands[b]);
                end
                // Strictly greater, so the lowest slot keeps a tie.
                if (s == 0 || sc > best_score) begin
                    best_score = sc;
                    best = s;
                end
            end
            lbl.class_label = class_ids[best];
            lbl.winner_slot = 4'(best);
            return lbl;
        endfunction

        function void note_input(t_in beat);
            case (beat.mode)
                MODE_LOAD_COEF: begin
                    if (int'(beat.feature_slot) <= BANDS_MAX) begin
                        weights[beat.class_slot][beat.feature_slot] = beat.load_value;
                    end
                end
                MODE_LOAD_CLASS: class_ids[beat.class_slot] = beat.load_value[15:0];
                MODE_CLASSIFY:   pending_labels = {pending_labels, score_pixel(beat)};
                default: ;
            endcase
        endfunction

        function void check_label(t_out got);
            t_out want;
            if (pending_labels.size() == 0) begin
                $error("result beat with no pixel pending: %p", got);
                fails++;
                return;
            end
            want = pending_labels.pop_front();
            if (got.class_label !== want.class_label) begin
                $error("class_label: expected %0d, got %0d", want.class_label, got.class_label);
                fails++;
            end
            if (got.winner_slot !== want.winner_slot) begin
                $error("winner_slot: expected %0d, got %0d", want.winner_slot, got.winner_slot);
                fails++;
            end
            if (got.no_data !== want.no_data) begin
                $error("no_data: expected %0b, got %0b", want.no_data, got.no_data);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    logic        calm          = 1'b0;
    logic        sink_hold_req = 1'b0;
    int unsigned sink_hold_left = 0;

    argmax_scoreboard sb = new();

    linear_score_argmax_classifier #(
        .MAX_BANDS   (BANDS_MAX),
        .MAX_CLASSES (SLOTS_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random back-pressure, one long hold on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_out_ready    <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req  <= 1'b0;
            sink_hold_left <= SINK_HOLD;
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_label(o_out_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic bit sender_pauses();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    function automatic t_in noise_beat();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in)-1:0];
    endfunction

    function automatic logic signed [31:0] rand_coef();
        int pick;
        int tiny;
        pick = $urandom_range(99);
        tiny = $urandom_range(6);
        if (pick < 5) return COEF_MAX;
        if (pick < 10) return COEF_MIN;
        // Small weights make equal scores, and so ties, likely.
        if (pick < 40) return tiny - 3;
        return $urandom;
    endfunction

    function automatic logic [15:0] rand_band();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return 16'h0000;
        if (pick < 30) return 16'hFFFF;
        if (pick < 60) return 16'($urandom_range(3));
        return 16'($urandom);
    endfunction

    function automatic t_in coef_beat(int slot, int feat, logic signed [31:0] value);
        t_in beat;
        beat              = noise_beat();
        beat.mode         = MODE_LOAD_COEF;
        beat.class_slot   = 4'(slot);
        beat.feature_slot = 4'(feat);
        beat.load_value   = value;
        return beat;
    endfunction

    function automatic t_in class_id_beat(int slot, logic [15:0] id);
        t_in beat;
        beat            = noise_beat();
        beat.mode       = MODE_LOAD_CLASS;
        beat.class_slot = 4'(slot);
        beat.load_value = {16'($urandom), id};
        return beat;
    endfunction

    function automatic t_in flat_pixel(logic [15:0] b0, logic [15:0] rest);
        t_in beat;
        beat            = noise_beat();
        beat.mode       = MODE_CLASSIFY;
        beat.band_zero  = b0;
        beat.band_one   = rest;
        beat.band_two   = rest;
        beat.band_three = rest;
        beat.band_four  = rest;
        beat.band_five  = rest;
        beat.band_six   = rest;
        beat.band_seven = rest;
        return beat;
    endfunction

    function automatic t_in random_pixel();
        t_in beat;
        beat            = noise_beat();
        beat.mode       = MODE_CLASSIFY;
        beat.band_zero  = rand_band();
        beat.band_one   = rand_band();
        beat.band_two   = rand_band();
        beat.band_three = rand_band();
        beat.band_four  = rand_band();
        beat.band_five  = rand_band();
        beat.band_six   = rand_band();
        beat.band_seven = rand_band();
        if (sb.nodata_en && $urandom_range(3) == 0) beat.band_zero = sb.nodata_val;
        return beat;
    endfunction

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input t_in beat);
        if (sender_pauses()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (sender_pauses()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(beat);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    // Upper data bits are random; the block must ignore them.
    task automatic apply_settings(input logic en, input logic [15:0] val,
                                  input logic [3:0] bc, input logic [4:0] cc);
        write_cfg(CFG_NODATA_EN, {15'($urandom), en});
        write_cfg(CFG_NODATA_VAL, val);
        write_cfg(CFG_IDX_W'(4 + $urandom_range(11)), 16'($urandom));
        write_cfg(CFG_BAND_CNT, {12'($urandom), bc});
        write_cfg(CFG_CLASS_CNT, {11'($urandom), cc});
        i_cfg_valid <= 1'b0;
    endtask

    // Registers change only once all pixels are out and any load has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_labels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_in         beat;
        int          done_items;
        int          pick;
        logic        en_cfg;
        logic [15:0] val_cfg;
        logic [3:0]  bc_cfg;
        logic [4:0]  cc_cfg;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every weight and class id is written before the first pixel.
        for (int s = 0; s < SLOTS_MAX; s++) begin
            for (int f = 0; f <= BANDS_MAX; f++) send_beat(coef_beat(s, f, rand_coef()));
            send_beat(class_id_beat(s, 16'($urandom)));
        end
        // Reset settings: the no-data test is off even where band 0 matches.
        send_beat(flat_pixel(16'h0000, 16'h0000));
        send_beat(flat_pixel(16'hFFFF, 16'hFFFF));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p < 5) begin
                en_cfg  = FIX_EN[p];
                val_cfg = FIX_VAL[p*16 +: 16];
                bc_cfg  = FIX_BC[p*4 +: 4];
                cc_cfg  = FIX_CC[p*5 +: 5];
            end else begin
                en_cfg  = 1'($urandom);
                val_cfg = 16'($urandom);
                bc_cfg  = 4'($urandom);
                cc_cfg  = 5'($urandom);
            end
            apply_settings(en_cfg, val_cfg, bc_cfg, cc_cfg);
            calm <= (p == 3);
            if (p == 5) sink_hold_req <= 1'b1;

            if (p == 0) begin
                send_beat(flat_pixel(16'hFFFF, 16'h0000));
                send_beat(flat_pixel(16'h0000, 16'h0000));
                send_beat(flat_pixel(16'hFFFE, 16'hFFFF));
                // Two slots with the top intercept: the lower one must win.
                send_beat(coef_beat(3, 0, COEF_MAX));
                send_beat(coef_beat(9, 0, COEF_MAX));
                send_beat(flat_pixel(16'h0000, 16'h0000));
                send_beat(coef_beat(7, BANDS_MAX, COEF_MAX));
                beat = flat_pixel(16'h0000, 16'h0000);
                beat.band_seven = 16'hFFFF;
                send_beat(beat);
                send_beat(coef_beat(0, 1, COEF_MIN));
                send_beat(flat_pixel(16'hFFFE, 16'h0000));
                send_beat(class_id_beat(3, 16'hFFFF));
                send_beat(class_id_beat(0, 16'h0000));
                // Loads past the last band and the unused mode change nothing.
                send_beat(coef_beat(0, BANDS_MAX + 1, COEF_MAX));
                send_beat(coef_beat(SLOTS_MAX - 1, 15, COEF_MIN));
                beat = noise_beat();
                beat.mode = MODE_UNUSED;
                send_beat(beat);
                send_beat(flat_pixel(16'h0000, 16'h0000));
                send_beat(flat_pixel(16'h0001, 16'h0001));
            end

            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_beat(random_pixel());
                    done_items++;
                end else if (pick < 80) begin
                    send_beat(coef_beat($urandom_range(SLOTS_MAX - 1),
                                        $urandom_range(BANDS_MAX), rand_coef()));
                    done_items++;
                end else if (pick < 92) begin
                    send_beat(class_id_beat($urandom_range(SLOTS_MAX - 1), 16'($urandom)));
                    done_items++;
                end else if (pick < 96) begin
                    send_beat(coef_beat($urandom_range(SLOTS_MAX - 1),
                                        BANDS_MAX + 1 + $urandom_range(15 - BANDS_MAX - 1),
                                        rand_coef()));
                end else begin
                    beat = noise_beat();
                    beat.mode = MODE_UNUSED;
                    send_beat(beat);
                end
            end
        end

        settle();
        if (sb.pending_labels.size() != 0) begin
            $error("%0d results never arrived", sb.pending_labels.size());
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
